// ===== rtl/twpa_pkg.sv =====
// Shared types and constants for the time-window point averager.
`default_nettype none
package twpa_pkg;

    localparam int STORE_DEPTH_DEF = 32;     // default store size
    localparam int CFG_IDX_W       = 1;      // register index width
    localparam int CFG_DATA_W      = 16;     // widest register
    localparam int COORD_W         = 16;     // x and y width
    localparam int TIME_W          = 32;     // timestamp width

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS     = 1'd1;

    localparam logic        FILTER_ENABLE_RST = 1'b1;
    localparam logic [15:0] WINDOW_MS_RST     = 16'd50;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/time_window_point_averager.sv =====
// Top level of the time-window point averager: sample store, expiry walk, mean divider.
`default_nettype none
// Smooths timestamped 2-D pointer samples. With filtering on, each accepted
// sample is written into a circular store of STORE_DEPTH entries (one
// synchronous RAM of {time, y, x} with a registered read; a valid bit per
// entry in flip-flops). The block then walks every entry once, dropping those
// whose age (new time minus stored time, modulo 2^32) exceeds window_ms and
// summing the rest, and divides both sums by the entry count with two
// restoring dividers side by side, one quotient bit per cycle, truncating
// toward zero. One item at a time: each filtered sample goes through the
// one-read-per-cycle store walk and the bit-serial divide of the SUM_W-bit
// sums (SUM_W = 16 + clog2(STORE_DEPTH + 1)), and the next sample is taken once
// its result is in the output register, where it may wait while the next
// transfer in is taken. Filtering off sends the sample straight there and
// leaves the store untouched. If the slot being written still holds a live
// entry it is overwritten and store_overflow is raised with that result. No
// clearing pass is needed after reset. Registers: index 0 filter_enable
// (reset 1), index 1 window_ms (reset 50); write them only while idle.
module time_window_point_averager #(
    parameter int STORE_DEPTH = twpa_pkg::STORE_DEPTH_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration
    input  wire                                  i_cfg_wr_en,
    input  wire  [twpa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [twpa_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // sample in
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  signed [twpa_pkg::COORD_W-1:0]  i_sample_x,
    input  wire  signed [twpa_pkg::COORD_W-1:0]  i_sample_y,
    input  wire  [twpa_pkg::TIME_W-1:0]          i_sample_time,
    // result out
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic signed [twpa_pkg::COORD_W-1:0]  o_mean_x,
    output logic signed [twpa_pkg::COORD_W-1:0]  o_mean_y,
    output logic [twpa_pkg::TIME_W-1:0]          o_out_time,
    output logic                                 o_store_overflow
);
    import twpa_pkg::*;

    localparam int IDX_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W   = COORD_W + CNT_W;
    localparam int DCNT_W  = $clog2(SUM_W);
    localparam int MEM_W   = TIME_W + 2 * COORD_W;
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(STORE_DEPTH - 1);
    localparam logic [DCNT_W-1:0] LAST_BIT = DCNT_W'(SUM_W - 1);

    // configuration registers
    logic        r_filter_en;
    logic [15:0] r_window;

    // control
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_wr_slot;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_chk_idx;
    logic               r_chk_vld;
    logic [STORE_DEPTH-1:0] r_valid;
    logic [DCNT_W-1:0]  r_bit;
    logic               r_out_valid;

    // item payload and working values
    logic signed [COORD_W-1:0] r_in_x, r_in_y;
    logic [TIME_W-1:0]         r_in_time;
    logic                      r_ovf;
    logic signed [SUM_W-1:0]   r_sum_x, r_sum_y;
    logic [CNT_W-1:0]          r_cnt;
    logic [SUM_W-1:0]          r_dvd_x, r_dvd_y;
    logic [CNT_W-1:0]          r_rem_x, r_rem_y;
    logic                      r_neg_x, r_neg_y;

    // sample store
    logic [MEM_W-1:0] mem [STORE_DEPTH];
    logic [MEM_W-1:0] r_rd_data;

    logic in_fire, out_load, store_wr, walk_rd;
    logic signed [COORD_W-1:0] rd_x, rd_y;
    logic [TIME_W-1:0]         rd_time, age;
    logic                      chk_live, chk_expire;
    logic [CNT_W:0]            sh_x, sh_y, dif_x, dif_y;
    logic                      qb_x, qb_y;
    logic [SUM_W-1:0]          q_x, q_y;

    // ---------------------------------------------------------------
    // Handshake and sequencer
    // ---------------------------------------------------------------
    assign in_fire  = i_in_valid && o_in_ready;
    assign store_wr = in_fire && r_filter_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        walk_rd    = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = r_filter_en ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK: begin
                walk_rd = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_PREP;
            ST_PREP:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_bit == LAST_BIT) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_en <= FILTER_ENABLE_RST;
            r_window    <= WINDOW_MS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FILTER_ENABLE: r_filter_en <= i_cfg_wdata[0];
                CFG_WINDOW_MS:     r_window    <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Store: new sample written on the transfer, then one read a cycle
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            mem[r_wr_slot] <= {i_sample_time, i_sample_y, i_sample_x};
        end
        if (walk_rd) begin
            r_rd_data <= mem[r_idx];
        end
    end

    assign rd_x    = r_rd_data[COORD_W-1:0];
    assign rd_y    = r_rd_data[2*COORD_W-1:COORD_W];
    assign rd_time = r_rd_data[MEM_W-1:2*COORD_W];
    assign age     = r_in_time - rd_time;    // wraps modulo 2^32

    assign chk_live   = r_chk_vld && r_valid[r_chk_idx];
    assign chk_expire = age > {{(TIME_W-16){1'b0}}, r_window};

    // walk pointers, write slot and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot <= '0;
            r_idx     <= '0;
            r_chk_vld <= 1'b0;
            r_valid   <= '0;
        end else begin
            r_chk_vld <= walk_rd;
            if (in_fire) begin
                r_idx <= '0;
            end else if (walk_rd && r_idx != LAST_IDX) begin
                r_idx <= r_idx + 1'b1;
            end
            if (store_wr) begin
                r_valid[r_wr_slot] <= 1'b1;
                r_wr_slot <= (r_wr_slot == LAST_IDX) ? '0 : r_wr_slot + 1'b1;
            end else if (chk_live && chk_expire) begin
                r_valid[r_chk_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_idx;
    end

    // capture the item and accumulate live entries
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_x    <= i_sample_x;
            r_in_y    <= i_sample_y;
            r_in_time <= i_sample_time;
            r_ovf     <= r_filter_en && r_valid[r_wr_slot];
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_cnt     <= '0;
        end else if (chk_live && !chk_expire) begin
            r_sum_x <= r_sum_x + SUM_W'(rd_x);
            r_sum_y <= r_sum_y + SUM_W'(rd_y);
            r_cnt   <= r_cnt + 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Restoring divide of |sum| by count, x and y side by side
    // ---------------------------------------------------------------
    assign sh_x  = {r_rem_x, r_dvd_x[SUM_W-1]};
    assign sh_y  = {r_rem_y, r_dvd_y[SUM_W-1]};
    assign dif_x = sh_x - {1'b0, r_cnt};
    assign dif_y = sh_y - {1'b0, r_cnt};
    assign qb_x  = !dif_x[CNT_W];
    assign qb_y  = !dif_y[CNT_W];

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP) begin
            r_neg_x <= r_sum_x[SUM_W-1];
            r_neg_y <= r_sum_y[SUM_W-1];
            r_dvd_x <= r_sum_x[SUM_W-1] ? SUM_W'(-r_sum_x) : SUM_W'(r_sum_x);
            r_dvd_y <= r_sum_y[SUM_W-1] ? SUM_W'(-r_sum_y) : SUM_W'(r_sum_y);
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_bit   <= '0;
        end else if (r_state == ST_DIV) begin
            r_rem_x <= qb_x ? dif_x[CNT_W-1:0] : sh_x[CNT_W-1:0];
            r_rem_y <= qb_y ? dif_y[CNT_W-1:0] : sh_y[CNT_W-1:0];
            r_dvd_x <= {r_dvd_x[SUM_W-2:0], qb_x};
            r_dvd_y <= {r_dvd_y[SUM_W-2:0], qb_y};
            r_bit   <= r_bit + 1'b1;
        end
    end

    assign q_x = r_neg_x ? SUM_W'(-r_dvd_x) : r_dvd_x;
    assign q_y = r_neg_y ? SUM_W'(-r_dvd_y) : r_dvd_y;

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            // filter off: r_ovf is zero and the sample passes straight out
            o_mean_x         <= r_filter_en ? q_x[COORD_W-1:0] : r_in_x;
            o_mean_y         <= r_filter_en ? q_y[COORD_W-1:0] : r_in_y;
            o_out_time       <= r_in_time;
            o_store_overflow <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    // the sample just stored must be live on the next cycle
    a_store_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_wr |=> r_valid[$past(r_wr_slot)])
        else $error("stored entry not marked valid");

    // the new entry always survives the walk, so the divisor is never zero
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PREP |-> r_cnt != '0)
        else $error("empty average at divide start");

    // restoring divide keeps the partial remainder below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> (r_rem_x < r_cnt && r_rem_y < r_cnt))
        else $error("divider remainder out of range");

    // write slot stays inside the store
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_wr_slot) < STORE_DEPTH)
        else $error("write slot beyond store depth");

    // a result is only loaded when the output register can take it
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a waiting transfer");
`endif

endmodule
`default_nettype wire
